// File: src/fslm_pkg.sv
// shared types, constants and helper functions of the fixed-string line matcher
`default_nettype none

package fslm_pkg;

  // sizes
  localparam int PATTERN_MAX      = 16;
  localparam int LINE_NUMBER_BITS = 24;
  localparam int WINDOW_DEPTH     = PATTERN_MAX + 1;
  localparam int WIN_IW           = $clog2(WINDOW_DEPTH);
  localparam int PIDX_W           = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W            = 5;
  localparam int COUNT_W          = 16;
  localparam int MAXC_W           = 17;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0]            BIL_MAX   = '1;
  localparam logic [LINE_NUMBER_BITS-1:0] LINE_MAX  = '1;
  localparam logic [COUNT_W-1:0]          COUNT_MAX = '1;
  localparam logic [MAXC_W-1:0]           MAXC_UNLIMITED = '1;
  localparam logic [7:0]                  CHAR_NUL  = 8'h00;
  localparam logic [7:0]                  CHAR_UNDERSCORE = 8'h5F;

  // input commands
  typedef enum logic [1:0] {
    CMD_TEXT = 2'd0,
    CMD_EOL  = 2'd1,
    CMD_EOF  = 2'd2
  } cmd_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_BINARY  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO     = 3'd0,
    CFG_PAT_HI     = 3'd1,
    CFG_PAT_LEN    = 3'd2,
    CFG_IGN_CASE   = 3'd3,
    CFG_MODE       = 3'd4,
    CFG_INVERT     = 3'd5,
    CFG_MAX_COUNT  = 3'd6,
    CFG_BIN_TEXT   = 3'd7
  } cfg_idx_e;

  // match mode bits
  localparam logic [1:0] MODE_WORD = 2'd1;

  typedef struct packed {
    logic [63:0]       pat_lo;
    logic [63:0]       pat_hi;
    logic [LEN_W-1:0]  pat_len;
    logic              ignore_case;
    logic [1:0]        match_mode;
    logic              invert;
    logic [MAXC_W-1:0] max_count;
    logic              bin_text;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [LINE_NUMBER_BITS-1:0] line_number;
    logic                        line_selected;
    logic [COUNT_W-1:0]          selected_count;
    logic                        file_matched;
    logic                        last_result;
  } result_t;

  // ascii case fold to lower
  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    if (ic && c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
    return c;
  endfunction

  // letters, digits and underscore
  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == CHAR_UNDERSCORE);
  endfunction

  // pattern length clamped to 1..PATTERN_MAX
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    if (l == '0) return LEN_W'(1);
    if (l > LEN_W'(PATTERN_MAX)) return LEN_W'(PATTERN_MAX);
    return l;
  endfunction

endpackage

`default_nettype wire

// File: src/fslm_in_if.sv
// input item channel of the line matcher
`default_nettype none

interface fslm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// File: src/fslm_out_if.sv
// result item channel of the line matcher
`default_nettype none

interface fslm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [23:0] line_number;
  logic        line_selected;
  logic [15:0] selected_count;
  logic        file_matched;
  logic        last_result;

  modport source (output valid, output result_kind, output line_number,
                  output line_selected, output selected_count,
                  output file_matched, output last_result, input ready);
  modport sink   (input valid, input result_kind, input line_number,
                  input line_selected, input selected_count,
                  input file_matched, input last_result, output ready);
endinterface

`default_nettype wire

// File: src/fixed_string_line_matcher.sv
// Fixed-string line matcher: takes one text byte, end of line or end of file
// command per cycle while the result queue has room, and reports a verdict per
// line, a binary-file notice and an end-of-file summary. An item is registered
// on acceptance and judged once the result queue has room, and its results are
// written into a four-entry result queue that drives the output. The sustained
// rate is one item per cycle while the queue has room; an end of file that
// closes an unjudged line yields two results. Input is held off only while the
// result queue has fewer than two free entries. There is no clearing pass after
// reset.
`default_nettype none

module fixed_string_line_matcher import fslm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  fslm_in_if.sink                    in_if,
  fslm_out_if.source                 out_if
);

  cfg_t cfg;

  // input register
  logic       in_valid_q;
  logic [1:0] in_cmd_q;
  logic [7:0] in_byte_q;

  // per-file state
  logic [LEN_W-1:0]            bil_q;
  logic                        lf_q, cwe_q, nul_q, stopped_q, binary_q;
  logic [LINE_NUMBER_BITS-1:0] lines_q;
  logic [COUNT_W-1:0]          sel_q;

  logic       room, consume;
  logic       is_text, do_text, do_judge, do_eof, push0, push1;
  logic       win_match, bnd_word;
  logic [LEN_W-1:0] len, bil_inc, bil_cmp;
  logic [LINE_NUMBER_BITS-1:0] lines_inc, lines_post;
  logic       is_bin, matched, selected, limited, limit_hit, jsel;
  logic [COUNT_W-1:0] limit_val, jcnt, sel_post;
  logic       bin_post;
  result_t    judge_res, sum_res, res0;

  fslm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake
  assign consume     = in_valid_q && room;
  assign in_if.ready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_cmd_q  <= in_if.command;
      in_byte_q <= in_if.data_byte;
    end
  end

  // command decode
  assign len      = eff_len(cfg.pat_len);
  assign is_text  = in_cmd_q == CMD_TEXT;
  assign do_text  = consume && is_text && !stopped_q;
  assign do_eof   = consume && (in_cmd_q == CMD_EOF);
  assign do_judge = consume && !stopped_q &&
                    ((in_cmd_q == CMD_EOL) || ((in_cmd_q == CMD_EOF) && (bil_q != '0)));

  assign bil_inc = (bil_q == BIL_MAX) ? bil_q : bil_q + LEN_W'(1);
  assign bil_cmp = is_text ? bil_inc : bil_q;

  fslm_window u_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (do_text),
    .clear_i    (do_eof),
    .use_new_i  (is_text),
    .byte_i     (in_byte_q),
    .bil_i      (bil_cmp),
    .cfg_i      (cfg),
    .match_o    (win_match),
    .bnd_word_o (bnd_word)
  );

  // line verdict
  always_comb begin
    lines_inc = (lines_q == LINE_MAX) ? lines_q : lines_q + LINE_NUMBER_BITS'(1);
    is_bin    = (lines_inc == LINE_NUMBER_BITS'(1)) && nul_q && !cfg.bin_text;
    if (cfg.match_mode[1]) begin
      matched = (bil_q == len) && win_match;
    end else if (cfg.match_mode == MODE_WORD) begin
      matched = lf_q || cwe_q;
    end else begin
      matched = lf_q;
    end
    selected  = matched ^ cfg.invert;
    limited   = cfg.max_count != MAXC_UNLIMITED;
    limit_val = cfg.max_count[MAXC_W-1] ? '0 : cfg.max_count[COUNT_W-1:0];
    limit_hit = selected && limited && (sel_q >= limit_val);
    jsel      = selected && !limit_hit;
    jcnt      = (jsel && sel_q != COUNT_MAX) ? sel_q + COUNT_W'(1) : sel_q;

    judge_res.kind           = is_bin ? KIND_BINARY : KIND_VERDICT;
    judge_res.line_number    = is_bin ? LINE_NUMBER_BITS'(1) : lines_inc;
    judge_res.line_selected  = is_bin ? 1'b0 : jsel;
    judge_res.selected_count = is_bin ? '0 : jcnt;
    judge_res.file_matched   = is_bin || (jcnt != '0) || binary_q;
    judge_res.last_result    = !do_eof;
  end

  // end-of-file summary, seen after any judge of the same item
  always_comb begin
    lines_post = do_judge ? lines_inc : lines_q;
    sel_post   = (do_judge && !is_bin) ? jcnt : sel_q;
    bin_post   = binary_q || (do_judge && is_bin);
    sum_res.kind           = KIND_SUMMARY;
    sum_res.line_number    = lines_post;
    sum_res.line_selected  = 1'b0;
    sum_res.selected_count = sel_post;
    sum_res.file_matched   = (sel_post != '0) || bin_post;
    sum_res.last_result    = 1'b1;
  end

  assign push0 = do_judge || do_eof;
  assign push1 = do_judge && do_eof;
  assign res0  = do_judge ? judge_res : sum_res;

  fslm_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .data0_i (res0),
    .data1_i (sum_res),
    .room_o  (room),
    .out_if  (out_if)
  );

  // per-file state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bil_q     <= '0;
      lf_q      <= 1'b0;
      cwe_q     <= 1'b0;
      nul_q     <= 1'b0;
      lines_q   <= '0;
      sel_q     <= '0;
      stopped_q <= 1'b0;
      binary_q  <= 1'b0;
    end else if (do_eof) begin
      bil_q     <= '0;
      lf_q      <= 1'b0;
      cwe_q     <= 1'b0;
      nul_q     <= 1'b0;
      lines_q   <= '0;
      sel_q     <= '0;
      stopped_q <= 1'b0;
      binary_q  <= 1'b0;
    end else if (do_judge) begin
      lines_q <= lines_inc;
      if (is_bin) begin
        binary_q  <= 1'b1;
        stopped_q <= 1'b1;
      end else begin
        sel_q <= jcnt;
        if (limit_hit) stopped_q <= 1'b1;
      end
      bil_q <= '0;
      lf_q  <= 1'b0;
      cwe_q <= 1'b0;
      nul_q <= 1'b0;
    end else if (do_text) begin
      bil_q <= bil_inc;
      if (in_byte_q == CHAR_NUL && lines_q == '0) nul_q <= 1'b1;
      if (!cfg.match_mode[1]) begin
        if (cfg.match_mode == MODE_WORD) begin
          if (cwe_q && !is_word(in_byte_q)) lf_q <= 1'b1;
          cwe_q <= win_match && ((bil_inc == len) || !bnd_word);
        end else if (win_match) begin
          lf_q <= 1'b1;
        end
      end
    end
  end

  // a binary notice stops the file unless end of file clears it at once
  a_bin_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_judge && is_bin && !do_eof |=> stopped_q && binary_q)
    else $error("binary file not stopped");

  // end of file clears the per-file counters
  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_eof |=> lines_q == '0 && sel_q == '0 && !stopped_q && bil_q == '0)
    else $error("file state not cleared");

  // a stopped file only ever yields a summary
  a_stopped_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !do_judge && !push1)
    else $error("verdict on stopped file");

endmodule

`default_nettype wire

// File: src/fslm_cfg_regs.sv
// configuration registers with write decode
`default_nettype none

module fslm_cfg_regs import fslm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_lo      <= '0;
      cfg_q.pat_hi      <= '0;
      cfg_q.pat_len     <= LEN_W'(1);
      cfg_q.ignore_case <= 1'b0;
      cfg_q.match_mode  <= '0;
      cfg_q.invert      <= 1'b0;
      cfg_q.max_count   <= MAXC_UNLIMITED;
      cfg_q.bin_text    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAT_LO:    cfg_q.pat_lo      <= cfg_data_i;
        CFG_PAT_HI:    cfg_q.pat_hi      <= cfg_data_i;
        CFG_PAT_LEN:   cfg_q.pat_len     <= cfg_data_i[LEN_W-1:0];
        CFG_IGN_CASE:  cfg_q.ignore_case <= cfg_data_i[0];
        CFG_MODE:      cfg_q.match_mode  <= cfg_data_i[1:0];
        CFG_INVERT:    cfg_q.invert      <= cfg_data_i[0];
        CFG_MAX_COUNT: cfg_q.max_count   <= cfg_data_i[MAXC_W-1:0];
        CFG_BIN_TEXT:  cfg_q.bin_text    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/fslm_window.sv
// recent byte window with parallel pattern compare and word boundary check
`default_nettype none

module fslm_window import fslm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             shift_en_i,
  input  wire logic             clear_i,
  input  wire logic             use_new_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic [LEN_W-1:0] bil_i,
  input  cfg_t                  cfg_i,
  output logic                  match_o,
  output logic                  bnd_word_o
);

  logic [7:0]       win_q   [WINDOW_DEPTH];
  logic [7:0]       new_win [WINDOW_DEPTH];
  logic [7:0]       pat_b   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;
  logic [LEN_W-1:0] len;

  assign len = eff_len(cfg_i.pat_len);

  // window after shifting in the current byte, newest first
  always_comb begin
    new_win[0] = byte_i;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      new_win[i] = win_q[i-1];
    end
  end

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) win_q[i] <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) win_q[i] <= '0;
    end else if (shift_en_i) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) win_q[i] <= new_win[i];
    end
  end

  // per-position compare: window byte k against pattern byte len-1-k
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cmp
    logic [LEN_W-1:0] pidx;
    logic [7:0]       cmp_b;

    if (k < 8) begin : g_lo
      assign pat_b[k] = cfg_i.pat_lo[8*k +: 8];
    end else begin : g_hi
      assign pat_b[k] = cfg_i.pat_hi[8*(k-8) +: 8];
    end

    assign pidx  = len - LEN_W'(k + 1);
    assign cmp_b = use_new_i ? new_win[k] : win_q[k];
    assign eq[k] = (LEN_W'(k) >= len) ||
                   (fold(cmp_b, cfg_i.ignore_case) ==
                    fold(pat_b[pidx[PIDX_W-1:0]], cfg_i.ignore_case));
  end

  assign match_o    = (bil_i >= len) && (&eq);
  // byte just before a match ending at the newest byte
  assign bnd_word_o = is_word(new_win[len[WIN_IW-1:0]]);

endmodule

`default_nettype wire

// File: src/fslm_out_fifo.sv
// result queue taking up to two items per cycle and giving one while the output is ready
`default_nettype none

module fslm_out_fifo import fslm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push0_i,
  input  wire logic  push1_i,
  input  result_t    data0_i,
  input  result_t    data1_i,
  output logic       room_o,
  fslm_out_if.source out_if
);

  result_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d, wr1;
  logic [FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                   pop;
  result_t                head;

  assign wr1  = wr_q + FIFO_PTR_W'(1);
  assign pop  = out_if.valid && out_if.ready;
  assign head = mem_q[rd_q];

  // pointers and fill count
  always_comb begin
    wr_d  = wr_q + FIFO_PTR_W'(push0_i) + FIFO_PTR_W'(push1_i);
    rd_d  = rd_q + FIFO_PTR_W'(pop);
    cnt_d = cnt_q + FIFO_CNT_W'(push0_i) + FIFO_CNT_W'(push1_i) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_q] <= data0_i;
    if (push1_i) mem_q[wr1]  <= data1_i;
  end

  assign room_o = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  // output side
  assign out_if.valid          = cnt_q != '0;
  assign out_if.result_kind    = head.kind;
  assign out_if.line_number    = head.line_number;
  assign out_if.line_selected  = head.line_selected;
  assign out_if.selected_count = head.selected_count;
  assign out_if.file_matched   = head.file_matched;
  assign out_if.last_result    = head.last_result;

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

`default_nettype wire
